/* design/varint_codec_macros.svh */
// Assertion macros shared by the varint codec checks.
`ifndef VARINT_CODEC_MACROS_SVH
`define VARINT_CODEC_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define VC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define VC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/vcodec_pkg.sv */
// Types and constants shared by the varint codec modules.
package vcodec_pkg;

    // Bits carried by one coded byte and the position of its continue flag.
    localparam int unsigned C_GROUP_BITS = 7;
    localparam int unsigned C_CONT_BIT   = 7;

    // Byte limits of a value in narrow (32-bit) and wide (64-bit) mode.
    localparam logic [3:0] C_NARROW_BYTES = 4'd5;
    localparam logic [3:0] C_WIDE_BYTES   = 4'd10;

    // Input item kinds.
    localparam logic C_KIND_ENCODE = 1'b0;
    localparam logic C_KIND_DECODE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [63:0] plain_value;
        logic        [7:0]  coded_byte;
    } t_in_item;

    typedef struct packed {
        logic        [7:0]  out_byte;
        logic               last_of_run;
        logic signed [63:0] decoded_value;
        logic               value_done;
        logic               too_long;
        logic        [3:0]  byte_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_dec;
        logic load_enc_first;
        logic load_enc_next;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first_last;
        logic next_last;
    } t_sts;

endpackage

/* design/varint_codec.sv */
// Top level of the unsigned LEB128 varint encoder and decoder.
//
// The block turns values into 7-bit-group varint bytes and back, in 32-bit
// (narrow) or 64-bit (wide) mode chosen by the single configuration register.
// An encode transaction emits one result transaction per byte, least
// significant group first, with the continue flag on every byte but the last;
// negative values take 5 bytes in narrow mode and 10 in wide mode. A decode
// transaction carries one byte and always yields exactly one result, which
// completes a value, reports an over-long run (clearing the decoder), or just
// reports the bytes consumed so far. A decode transaction leaves the input
// free, so bytes may stream in back to back while the output is not stalled.
// An encode transaction keeps the input stalled until the last of its bytes
// (1 to 5 narrow, 1 to 10 wide) has been loaded, because the single output
// register takes one byte per cycle while the output is not stalled. Every
// result is registered and appears in the cycle after its load command. A result
// held in the output register by a stalled output keeps the input stalled as
// well; the next input transaction is taken no earlier than the cycle in which
// the waiting result is accepted. The configuration port is always ready and
// must only be written while the block is idle.
module varint_codec
    import vcodec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

`include "varint_codec_macros.svh"

    t_cmd cmd;
    t_sts sts;
    logic wide_mode;
    logic in_accept;

    // The mode register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller owns both handshakes and sequences multi-byte encodes.
    vcodec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_item.kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // The datapath holds the mode, the encode shifter, the decode state and
    // the output register.
    vcodec_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_item  (o_out_item),
        .o_wide_mode (wide_mode)
    );

    assign in_accept = i_in_valid && !o_in_stall;

    // A decode transaction always produces its single result on the next cycle.
    `VC_ASSERT_NEXT(a_dec_result, in_accept && (i_in_item.kind == C_KIND_DECODE), o_out_valid && o_out_item.last_of_run, "decode transaction gave no final result")

    // An over-long run never also reports a completed value.
    `VC_ASSERT_NOW(a_err_excl, o_out_valid && o_out_item.too_long, !o_out_item.value_done && o_out_item.last_of_run, "error result also marked done")

    // In narrow mode, no encode byte other than the last of its run reaches the narrow byte limit.
    `VC_ASSERT_NOW(a_cnt_range, o_out_valid && !wide_mode && !o_out_item.last_of_run, o_out_item.byte_count < C_NARROW_BYTES, "narrow encode ran past five bytes")

endmodule

/* design/vcodec_ctrl.sv */
// Controller state machine of the varint codec: handshakes and encode sequencing.
module vcodec_ctrl
    import vcodec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_ENC  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;
    logic   in_accept;

    // The output register may be reloaded when it is empty or being emptied.
    assign can_load  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !can_load;
    assign in_accept = i_in_valid && !o_in_stall;

    assign o_cmd.load_dec       = in_accept && (i_in_kind == C_KIND_DECODE);
    assign o_cmd.load_enc_first = in_accept && (i_in_kind == C_KIND_ENCODE);
    assign o_cmd.load_enc_next  = (r_state == S_ENC) && can_load;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load_enc_first && !i_sts.first_last) begin
                    n_state = S_ENC;
                end
            end
            S_ENC: begin
                if (o_cmd.load_enc_next && i_sts.next_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_dec || o_cmd.load_enc_first || o_cmd.load_enc_next) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/vcodec_dp.sv */
// Datapath of the varint codec: mode register, encode shifter, decode accumulator, output register.
module vcodec_dp
    import vcodec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_out_item,
    output logic      o_wide_mode
);

    logic        r_wide, n_wide;
    logic [63:0] r_acc, n_acc;
    logic [6:0]  r_shift, n_shift;
    logic [3:0]  r_dec_cnt, n_dec_cnt;
    logic [63:0] r_enc_val, n_enc_val;
    logic [3:0]  r_enc_cnt, n_enc_cnt;
    t_out_item   r_out, n_out;

    logic [63:0] enc_first_val;
    logic [63:0] group_shifted;
    logic [63:0] acc_sum;
    logic [63:0] done_val;
    logic [3:0]  dec_cnt_inc;
    logic [3:0]  enc_cnt_inc;
    logic [3:0]  limit;
    logic        cont;

    // Narrow mode encodes only the low word, zero-extended.
    assign enc_first_val = r_wide ? 64'(i_in_item.plain_value)
                                  : {32'd0, i_in_item.plain_value[31:0]};

    // A byte is the last one once nothing remains above its group.
    assign o_sts.first_last = (enc_first_val[63:C_GROUP_BITS] == '0);
    assign o_sts.next_last  = (r_enc_val[63:C_GROUP_BITS] == '0);

    assign enc_cnt_inc = r_enc_cnt + 4'd1;
    assign dec_cnt_inc = r_dec_cnt + 4'd1;
    assign limit       = r_wide ? C_WIDE_BYTES : C_NARROW_BYTES;
    assign cont        = i_in_item.coded_byte[C_CONT_BIT];

    // Groups at a shift of 64 or more fall off the top of the accumulator.
    assign group_shifted = r_shift[6] ? 64'd0
                         : ({57'd0, i_in_item.coded_byte[6:0]} << r_shift[5:0]);
    assign acc_sum = r_acc | group_shifted;
    assign done_val = r_wide ? acc_sum : {{32{acc_sum[31]}}, acc_sum[31:0]};

    always_comb begin
        n_wide    = r_wide;
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_dec_cnt = r_dec_cnt;
        n_enc_val = r_enc_val;
        n_enc_cnt = r_enc_cnt;
        n_out     = r_out;

        if (i_cfg_we) begin
            n_wide = i_cfg_data;
        end

        priority if (i_cmd.load_dec) begin
            n_out.out_byte      = 8'd0;
            n_out.last_of_run   = 1'b1;
            n_out.decoded_value = '0;
            n_out.value_done    = 1'b0;
            n_out.too_long      = 1'b0;
            n_out.byte_count    = dec_cnt_inc;
            if (!cont) begin
                n_out.decoded_value = done_val;
                n_out.value_done    = 1'b1;
                n_acc     = '0;
                n_shift   = '0;
                n_dec_cnt = '0;
            end else if (dec_cnt_inc >= limit) begin
                n_out.too_long = 1'b1;
                n_acc     = '0;
                n_shift   = '0;
                n_dec_cnt = '0;
            end else begin
                n_acc     = acc_sum;
                n_shift   = r_shift + 7'(C_GROUP_BITS);
                n_dec_cnt = dec_cnt_inc;
            end
        end else if (i_cmd.load_enc_first) begin
            n_out.out_byte      = {!o_sts.first_last, enc_first_val[6:0]};
            n_out.last_of_run   = o_sts.first_last;
            n_out.decoded_value = '0;
            n_out.value_done    = 1'b0;
            n_out.too_long      = 1'b0;
            n_out.byte_count    = 4'd1;
            n_enc_val = enc_first_val >> C_GROUP_BITS;
            n_enc_cnt = 4'd1;
        end else if (i_cmd.load_enc_next) begin
            n_out.out_byte      = {!o_sts.next_last, r_enc_val[6:0]};
            n_out.last_of_run   = o_sts.next_last;
            n_out.decoded_value = '0;
            n_out.value_done    = 1'b0;
            n_out.too_long      = 1'b0;
            n_out.byte_count    = enc_cnt_inc;
            n_enc_val = r_enc_val >> C_GROUP_BITS;
            n_enc_cnt = enc_cnt_inc;
        end else begin
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide    <= 1'b0;
            r_acc     <= '0;
            r_shift   <= '0;
            r_dec_cnt <= '0;
        end else begin
            r_wide    <= n_wide;
            r_acc     <= n_acc;
            r_shift   <= n_shift;
            r_dec_cnt <= n_dec_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_enc_val <= n_enc_val;
        r_enc_cnt <= n_enc_cnt;
        r_out     <= n_out;
    end

    assign o_out_item  = r_out;
    assign o_wide_mode = r_wide;

endmodule
